>>> sv/rsn_pkg.sv
package rsn_pkg;

  localparam int BYTE_W      = 8;
  localparam int YEAR_W      = 15;
  localparam int BASE_W      = 14;
  localparam int TZ_W        = 5;
  localparam int Q_W         = 8;
  localparam int NUM_LANES   = 7;

  // lane order inside a snapshot
  localparam int LANE_SEC    = 0;
  localparam int LANE_MIN    = 1;
  localparam int LANE_HOUR   = 2;
  localparam int LANE_DAY    = 3;
  localparam int LANE_MON    = 4;
  localparam int LANE_YEAR   = 5;
  localparam int LANE_CEN    = 6;

  // status B bits
  localparam int SB_BIN_BIT  = 2;
  localparam int SB_24H_BIT  = 1;

  // configuration port
  localparam int CFG_DW      = 32;
  localparam int CFG_AW      = 4;
  localparam int CFG_IW      = CFG_AW - 2;

  typedef enum logic [CFG_IW-1:0] {
    REG_CENTURY = 2'd0,
    REG_TZ      = 2'd1,
    REG_BASE    = 2'd2
  } cfg_reg_t;

  localparam logic [BASE_W-1:0] BASE_YEAR_RST = 14'd2024;
  localparam int                CENTURY_SPAN  = 100;
  // floor(x / 100) == (x * 5243) >> 19 for every 14-bit x
  localparam int                DIV100_MUL    = 5243;
  localparam int                DIV100_SHIFT  = 19;
  localparam int                DIV_PROD_W    = DIV100_SHIFT + Q_W;
  localparam logic [Q_W-1:0]    BASE_Q_RST    = Q_W'(int'(BASE_YEAR_RST) / CENTURY_SPAN);

  typedef struct packed {
    logic load;
    logic bin_mode;
  } lane_ctl_t;

  typedef struct packed {
    logic              match;
    logic              h24;
    logic [BYTE_W-1:0] sec;
    logic [BYTE_W-1:0] min;
    logic [BYTE_W-1:0] hr;
    logic [BYTE_W-1:0] day;
    logic [BYTE_W-1:0] mon;
    logic [BYTE_W-1:0] yr;
    logic [BYTE_W-1:0] cen;
  } s1_t;

  typedef struct packed {
    logic              century_present;
    logic [TZ_W-1:0]   tz;
    logic [BASE_W-1:0] base_year;
    logic [Q_W-1:0]    base_q;
  } cfg_t;

endpackage

>>> sv/rsn_in_if.sv
interface rsn_in_if;
  import rsn_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] raw_second;
  logic [BYTE_W-1:0] raw_minute;
  logic [BYTE_W-1:0] raw_hour;
  logic [BYTE_W-1:0] raw_day;
  logic [BYTE_W-1:0] raw_month;
  logic [BYTE_W-1:0] raw_year;
  logic [BYTE_W-1:0] raw_century;
  logic [BYTE_W-1:0] status_b;
  logic              update_busy;

  modport source (
    output valid, raw_second, raw_minute, raw_hour, raw_day, raw_month, raw_year,
           raw_century, status_b, update_busy,
    input  ready
  );

  modport sink (
    input  valid, raw_second, raw_minute, raw_hour, raw_day, raw_month, raw_year,
           raw_century, status_b, update_busy,
    output ready
  );

endinterface

>>> sv/rsn_out_if.sv
interface rsn_out_if;
  import rsn_pkg::*;

  logic              valid;
  logic              ready;
  logic              stable;
  logic [BYTE_W-1:0] out_second;
  logic [BYTE_W-1:0] out_minute;
  logic [BYTE_W-1:0] out_hour;
  logic [BYTE_W-1:0] out_day;
  logic [BYTE_W-1:0] out_month;
  logic [YEAR_W-1:0] out_year;

  modport source (
    output valid, stable, out_second, out_minute, out_hour, out_day, out_month, out_year,
    input  ready
  );

  modport sink (
    input  valid, stable, out_second, out_minute, out_hour, out_day, out_month, out_year,
    output ready
  );

endinterface

>>> sv/rsn_lane.sv
module rsn_lane (
  input  logic                      clk,
  input  rsn_pkg::lane_ctl_t        ctl,
  input  logic                      hour_mode,
  input  logic [rsn_pkg::BYTE_W-1:0] raw,
  output logic                      eq,
  output logic [rsn_pkg::BYTE_W-1:0] dec
);
  import rsn_pkg::*;

  logic [BYTE_W-1:0] prev_r;
  logic [BYTE_W-1:0] tens;
  logic [BYTE_W-1:0] bcd_val;

  // hour byte keeps bit 7 (PM flag) out of the tens digit
  always_comb begin
    tens = hour_mode ? {5'd0, raw[6:4]} : {4'd0, raw[7:4]};
    bcd_val = BYTE_W'({4'd0, raw[3:0]} + tens * BYTE_W'(10));
    if (hour_mode) begin
      bcd_val = bcd_val | {raw[7], 7'd0};
    end
    dec = ctl.bin_mode ? raw : bcd_val;
  end

  assign eq = (prev_r == raw);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prev_r <= raw;
    end
  end

endmodule

>>> sv/rsn_merge.sv
module rsn_merge (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s1_valid,
  input  rsn_pkg::s1_t   s1,
  input  rsn_pkg::cfg_t  cfg,
  output logic           s1_ready,
  rsn_out_if.source      out_ch
);
  import rsn_pkg::*;

  logic              out_valid_r;
  logic              stable_r;
  logic [BYTE_W-1:0] sec_r, min_r, hr_r, day_r, mon_r;
  logic [YEAR_W-1:0] year_r;

  logic [BYTE_W-1:0] hr_12;
  logic [BYTE_W-1:0] hr_24;
  logic [BYTE_W-1:0] hr_fin;
  logic [YEAR_W-1:0] cen_term;
  logic [YEAR_W-1:0] floor_year;
  logic [YEAR_W-1:0] win_year;
  logic [YEAR_W-1:0] win_fix;
  logic [YEAR_W-1:0] year_fin;

  // x stays below 140 here
  function automatic logic [BYTE_W-1:0] mod24(input logic [BYTE_W-1:0] x);
    logic [BYTE_W-1:0] r;
    if (x >= 8'd120) r = x - 8'd120;
    else if (x >= 8'd96) r = x - 8'd96;
    else if (x >= 8'd72) r = x - 8'd72;
    else if (x >= 8'd48) r = x - 8'd48;
    else if (x >= 8'd24) r = x - 8'd24;
    else r = x;
    return r;
  endfunction

  always_comb begin
    hr_12 = {1'b0, s1.hr[6:0]} + 8'd12;
    hr_24 = (!s1.h24 && s1.hr[7]) ? mod24(hr_12) : s1.hr;
    hr_fin = hr_24 + {3'd0, cfg.tz};

    cen_term   = YEAR_W'(s1.cen) * YEAR_W'(CENTURY_SPAN);
    floor_year = YEAR_W'(cfg.base_q) * YEAR_W'(CENTURY_SPAN);
    win_year   = floor_year + YEAR_W'(s1.yr);
    win_fix    = (win_year < YEAR_W'(cfg.base_year)) ? win_year + YEAR_W'(CENTURY_SPAN)
                                                     : win_year;
    year_fin   = cfg.century_present ? cen_term + YEAR_W'(s1.yr) : win_fix;
  end

  assign s1_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      stable_r <= s1.match;
      sec_r    <= s1.match ? s1.sec : '0;
      min_r    <= s1.match ? s1.min : '0;
      hr_r     <= s1.match ? hr_fin : '0;
      day_r    <= s1.match ? s1.day : '0;
      mon_r    <= s1.match ? s1.mon : '0;
      year_r   <= s1.match ? year_fin : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.stable     = stable_r;
  assign out_ch.out_second = sec_r;
  assign out_ch.out_minute = min_r;
  assign out_ch.out_hour   = hr_r;
  assign out_ch.out_day    = day_r;
  assign out_ch.out_month  = mon_r;
  assign out_ch.out_year   = year_r;

endmodule

>>> sv/rtc_snapshot_normalizer.sv
// Reads the raw clock registers one snapshot per item and reports a normalized time once two
// consecutive non-busy snapshots agree. Every accepted item gives exactly one result; only the
// matching one has stable set, all others (busy, first, or differing) come out as zeros. The
// block takes one item per clock unless the output stalls: seven byte lanes compare against the
// held snapshot and do the BCD decode in the accept cycle into a stage-1 register, and a merge
// stage does the 12/24-hour fix, timezone add and year completion into the output register.
// Registers: 0x0 century_present, 0x4 tz_offset_hours, 0x8 base_year (reset 2024).
module rtc_snapshot_normalizer (
  input  logic                       clk,
  input  logic                       rst_n,
  rsn_in_if.sink                     in_ch,
  rsn_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [rsn_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [rsn_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rsn_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import rsn_pkg::*;

  logic              century_present_r;
  logic [TZ_W-1:0]   tz_r;
  logic [BASE_W-1:0] base_year_r;
  logic [Q_W-1:0]    base_q_r;

  logic                  cfg_wr;
  cfg_reg_t              cfg_idx;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [Q_W-1:0]        base_q_nxt;
  cfg_t                  cfg;

  logic              have_prev_r;
  logic              have_prev_nxt;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  s1_t               s1_r;
  logic              s1_ready;
  logic              in_fire;
  logic              match;
  lane_ctl_t         lane_ctl;
  logic [BYTE_W-1:0] lane_raw [NUM_LANES];
  logic [BYTE_W-1:0] lane_dec [NUM_LANES];
  logic [NUM_LANES-1:0] lane_eq;

  // ---------------- configuration ----------------
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_pready = 1'b1;
  assign div_prod   = DIV_PROD_W'(cfg_pwdata[BASE_W-1:0]) * DIV_PROD_W'(DIV100_MUL);
  assign base_q_nxt = div_prod[DIV_PROD_W-1:DIV100_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      century_present_r <= 1'b0;
      tz_r              <= '0;
      base_year_r       <= BASE_YEAR_RST;
      base_q_r          <= BASE_Q_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CENTURY: century_present_r <= cfg_pwdata[0];
        REG_TZ:      tz_r              <= cfg_pwdata[TZ_W-1:0];
        REG_BASE: begin
          base_year_r <= cfg_pwdata[BASE_W-1:0];
          base_q_r    <= base_q_nxt;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTURY: cfg_prdata = CFG_DW'(century_present_r);
      REG_TZ:      cfg_prdata = CFG_DW'(tz_r);
      REG_BASE:    cfg_prdata = CFG_DW'(base_year_r);
      default:     cfg_prdata = '0;
    endcase
  end

  assign cfg.century_present = century_present_r;
  assign cfg.tz              = tz_r;
  assign cfg.base_year       = base_year_r;
  assign cfg.base_q          = base_q_r;

  // ---------------- lanes ----------------
  assign lane_raw[LANE_SEC]  = in_ch.raw_second;
  assign lane_raw[LANE_MIN]  = in_ch.raw_minute;
  assign lane_raw[LANE_HOUR] = in_ch.raw_hour;
  assign lane_raw[LANE_DAY]  = in_ch.raw_day;
  assign lane_raw[LANE_MON]  = in_ch.raw_month;
  assign lane_raw[LANE_YEAR] = in_ch.raw_year;
  assign lane_raw[LANE_CEN]  = century_present_r ? in_ch.raw_century : '0;

  assign in_ch.ready = !s1_valid_r || s1_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign match       = !in_ch.update_busy && have_prev_r && (&lane_eq);

  assign lane_ctl.load     = in_fire && !in_ch.update_busy && !match;
  assign lane_ctl.bin_mode = in_ch.status_b[SB_BIN_BIT];

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rsn_lane u_lane (
      .clk       (clk),
      .ctl       (lane_ctl),
      .hour_mode (i == LANE_HOUR),
      .raw       (lane_raw[i]),
      .eq        (lane_eq[i]),
      .dec       (lane_dec[i])
    );
  end

  // ---------------- stage 1 ----------------
  always_comb begin
    have_prev_nxt = have_prev_r;
    if (in_fire && !in_ch.update_busy) begin
      have_prev_nxt = !match;
    end
    s1_valid_nxt = in_fire || (s1_valid_r && !s1_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.match <= match;
      s1_r.h24   <= in_ch.status_b[SB_24H_BIT];
      s1_r.sec   <= lane_dec[LANE_SEC];
      s1_r.min   <= lane_dec[LANE_MIN];
      s1_r.hr    <= lane_dec[LANE_HOUR];
      s1_r.day   <= lane_dec[LANE_DAY];
      s1_r.mon   <= lane_dec[LANE_MON];
      s1_r.yr    <= lane_dec[LANE_YEAR];
      s1_r.cen   <= lane_dec[LANE_CEN];
    end
  end

  rsn_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1       (s1_r),
    .cfg      (cfg),
    .s1_ready (s1_ready),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_match_clears_store: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && match) |=> !have_prev_r)
    else $error("store not cleared after a matching item");

  a_busy_keeps_store: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.update_busy) |=> $stable(have_prev_r))
    else $error("busy item changed the store");

  a_match_needs_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && match) |-> (have_prev_r && !lane_ctl.load))
    else $error("match without a held snapshot");

  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_ready) |=> (s1_valid_r && $stable(s1_r)))
    else $error("stage 1 item lost while stalled");
`endif

endmodule

>>> bench/tb_rtc_snapshot_normalizer.sv
`timescale 1ns / 100ps

module tb_rtc_snapshot_normalizer;
  import rsn_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] sec;
    logic [BYTE_W-1:0] min;
    logic [BYTE_W-1:0] hr;
    logic [BYTE_W-1:0] day;
    logic [BYTE_W-1:0] mon;
    logic [BYTE_W-1:0] yr;
    logic [BYTE_W-1:0] cen;
    logic [BYTE_W-1:0] sb;
    logic              busy;
  } snapshot_t;

  typedef struct packed {
    logic              stable;
    logic [BYTE_W-1:0] sec;
    logic [BYTE_W-1:0] min;
    logic [BYTE_W-1:0] hr;
    logic [BYTE_W-1:0] day;
    logic [BYTE_W-1:0] mon;
    logic [YEAR_W-1:0] year;
  } clock_time_t;

  class time_scoreboard;
    logic                          century_on;
    logic [TZ_W-1:0]               tz_hours;
    logic [BASE_W-1:0]             cur_year;
    logic [NUM_LANES*BYTE_W-1:0]   held;
    logic                          held_valid;
    clock_time_t                   pending[$];
    int                            faults;
    int                            stable_seen;

    function new();
      century_on  = 1'b0;
      tz_hours    = '0;
      cur_year    = BASE_YEAR_RST;
      held        = '0;
      held_valid  = 1'b0;
      faults      = 0;
      stable_seen = 0;
    endfunction

    function void set_register(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_CENTURY: century_on = value[0];
        REG_TZ:      tz_hours   = value[TZ_W-1:0];
        REG_BASE:    cur_year   = value[BASE_W-1:0];
        default:     ;
      endcase
    endfunction

    function int bcd_value(logic [BYTE_W-1:0] v);
      return int'(v[3:0]) + int'(v[7:4]) * 10;
    endfunction

    // Works out the result of one accepted snapshot and queues it.
    function void note_snapshot(snapshot_t s);
      logic [NUM_LANES*BYTE_W-1:0] key;
      clock_time_t r;
      int sec, mn, hr, dy, mo, yr, cen;
      r   = '0;
      key = {s.sec, s.min, s.hr, s.day, s.mon, s.yr, century_on ? s.cen : 8'h00};
      if (!s.busy) begin
        if (!held_valid || held != key) begin
          held       = key;
          held_valid = 1'b1;
        end else begin
          held       = '0;
          held_valid = 1'b0;
          sec = s.sec;
          mn  = s.min;
          hr  = s.hr;
          dy  = s.day;
          mo  = s.mon;
          yr  = s.yr;
          cen = century_on ? int'(s.cen) : 0;
          if (!s.sb[SB_BIN_BIT]) begin
            sec = bcd_value(s.sec);
            mn  = bcd_value(s.min);
            // hour keeps its PM flag through the decode
            hr  = (int'(s.hr[3:0]) + int'(s.hr[6:4]) * 10) | (int'(s.hr) & 'h80);
            dy  = bcd_value(s.day);
            mo  = bcd_value(s.mon);
            yr  = bcd_value(s.yr);
            cen = bcd_value(8'(cen));
          end
          if (!s.sb[SB_24H_BIT] && (hr & 'h80) != 0)
            hr = ((hr & 'h7F) + 12) % 24;
          if (century_on) begin
            yr = yr + cen * CENTURY_SPAN;
          end else begin
            yr = yr + (int'(cur_year) / CENTURY_SPAN) * CENTURY_SPAN;
            if (yr < int'(cur_year))
              yr = yr + CENTURY_SPAN;
          end
          r.stable = 1'b1;
          r.sec    = 8'(sec);
          r.min    = 8'(mn);
          r.hr     = 8'(hr + int'(tz_hours));
          r.day    = 8'(dy);
          r.mon    = 8'(mo);
          r.year   = YEAR_W'(yr);
          stable_seen++;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(clock_time_t got);
      clock_time_t want;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: result with nothing outstanding: stable=%0d h=%0d y=%0d",
                   $realtime, got.stable, got.hr, got.year);
        return;
      end
      want = pending.pop_front();
      if (got.stable !== want.stable || got.sec !== want.sec || got.min !== want.min ||
          got.hr !== want.hr || got.day !== want.day || got.mon !== want.mon ||
          got.year !== want.year) begin
        faults++;
        if (faults <= 10) begin
          $display("%0t: mismatch expected st=%0d %0d:%0d:%0d d=%0d m=%0d y=%0d", $realtime,
                   want.stable, want.hr, want.min, want.sec, want.day, want.mon, want.year);
          $display("%0t:          actual   st=%0d %0d:%0d:%0d d=%0d m=%0d y=%0d", $realtime,
                   got.stable, got.hr, got.min, got.sec, got.day, got.mon, got.year);
        end
      end
    endfunction

    function int failures();
      return faults + pending.size();
    endfunction
  endclass

  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 6;
  localparam int NUM_PLANS    = 6;
  localparam int PLAN_ITEMS   = 220;
  localparam int CHUNK_ITEMS  = 40;
  localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic cp;
    int   tz;
    int   base;
  } reg_plan_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  rsn_in_if  in_ch ();
  rsn_out_if out_ch ();

  time_scoreboard board;
  int  snapshots_taken = 0;
  int  idle_cycles = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;

  reg_plan_t plans [NUM_PLANS] = '{
    '{1'b1, 23, 9999}, '{1'b0, 23, 1970}, '{1'b0, 5, 9999},
    '{1'b1, 0, 1970},  '{1'b0, 12, 2050}, '{1'b1, 7, 2024}
  };

  rtc_snapshot_normalizer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] field_value(int lo, int hi, logic bin_mode);
    int v;
    if ($urandom_range(0, 99) < 12) return 8'($urandom_range(0, 255));
    v = $urandom_range(lo, hi);
    return bin_mode ? 8'(v) : 8'(((v / 10) << 4) | (v % 10));
  endfunction

  function automatic snapshot_t random_snapshot();
    snapshot_t s;
    logic      bin;
    s.sb   = 8'($urandom_range(0, 255));
    bin    = s.sb[SB_BIN_BIT];
    s.sec  = field_value(0, 59, bin);
    s.min  = field_value(0, 59, bin);
    if (s.sb[SB_24H_BIT])
      s.hr = field_value(0, 23, bin);
    else
      s.hr = field_value(1, 12, bin) | ($urandom_range(0, 1) ? 8'h80 : 8'h00);
    s.day  = field_value(1, 31, bin);
    s.mon  = field_value(1, 12, bin);
    s.yr   = field_value(0, 99, bin);
    s.cen  = field_value(19, 21, bin);
    s.busy = 1'b0;
    return s;
  endfunction

  function automatic snapshot_t noise_snapshot(logic busy);
    snapshot_t s;
    s      = snapshot_t'({$urandom(), $urandom(), $urandom()});
    s.busy = busy;
    return s;
  endfunction

  task automatic present_snapshot(snapshot_t s);
    int g;
    in_ch.valid       <= 1'b1;
    in_ch.raw_second  <= s.sec;
    in_ch.raw_minute  <= s.min;
    in_ch.raw_hour    <= s.hr;
    in_ch.raw_day     <= s.day;
    in_ch.raw_month   <= s.mon;
    in_ch.raw_year    <= s.yr;
    in_ch.raw_century <= s.cen;
    in_ch.status_b    <= s.sb;
    in_ch.update_busy <= s.busy;
    do @(posedge clk); while (!in_ch.ready);
    board.note_snapshot(s);
    if (!s.busy) snapshots_taken++;
    g = (!in_calm && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup then access phase, plus an idle phase with psel low so back-to-back writes stay clean
  task automatic program_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    board.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic directed_items();
    snapshot_t a;
    snapshot_t b;
    a = '0;
    // all-zero snapshot right after reset must not count as a match
    present_snapshot(a);
    present_snapshot(a);
    present_snapshot(a);
    present_snapshot(noise_snapshot(1'b0) | 65'd1);
    a.busy = 1'b0;
    present_snapshot(a);
    // 12 PM in BCD, century byte differs but is not read
    a = '{sec: 8'h59, min: 8'h59, hr: 8'h92, day: 8'h31, mon: 8'h12, yr: 8'h99,
          cen: 8'h20, sb: 8'h00, busy: 1'b0};
    present_snapshot(a);
    b = noise_snapshot(1'b1);
    present_snapshot(b);
    a.cen = 8'h19;
    present_snapshot(a);
    // bad BCD digits everywhere
    a = '{sec: 8'hFF, min: 8'hFF, hr: 8'hFF, day: 8'hFF, mon: 8'hFF, yr: 8'hFF,
          cen: 8'hFF, sb: 8'h00, busy: 1'b0};
    present_snapshot(a);
    present_snapshot(a);
    // binary, 24-hour, PM flag kept
    a.sb = 8'hFF;
    present_snapshot(a);
    present_snapshot(a);
    // status B taken from the matching snapshot only
    a.sb = 8'h06;
    present_snapshot(a);
    a.sb = 8'h04;
    present_snapshot(a);
    a = '{sec: 8'h45, min: 8'h30, hr: 8'h81, day: 8'h01, mon: 8'h01, yr: 8'h00,
          cen: 8'h00, sb: 8'h02, busy: 1'b0};
    present_snapshot(a);
    present_snapshot(a);
    b = a;
    b.sec = 8'h46;
    present_snapshot(a);
    present_snapshot(b);
    drain();
    program_reg(REG_UNUSED, 32'hFFFF_FFFF);
  endtask

  task automatic random_items(int count);
    int        goal;
    int        kind;
    snapshot_t a;
    snapshot_t b;
    goal = snapshots_taken + count;
    while (snapshots_taken < goal) begin
      if ((snapshots_taken % CHUNK_ITEMS) == 0) begin
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 99);
      a = random_snapshot();
      if (kind < 65) begin
        present_snapshot(a);
        if ($urandom_range(0, 99) < 20) present_snapshot(noise_snapshot(1'b1));
        b = a;
        if ($urandom_range(0, 99) < 30) b.sb = 8'($urandom_range(0, 255));
        if (!board.century_on && $urandom_range(0, 1)) b.cen = 8'($urandom_range(0, 255));
        present_snapshot(b);
        if ($urandom_range(0, 99) < 10) present_snapshot(b);
      end else if (kind < 80) begin
        b = a ^ (65'd1 << $urandom_range(9, 64));
        present_snapshot(a);
        present_snapshot(b);
      end else if (kind < 90) begin
        present_snapshot(noise_snapshot(1'($urandom_range(0, 1))));
      end else begin
        a.busy = 1'b1;
        present_snapshot(a);
      end
    end
    in_calm  = 1'b0;
    out_calm = 1'b0;
  endtask

  initial begin
    board = new();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.raw_second  <= '0;
    in_ch.raw_minute  <= '0;
    in_ch.raw_hour    <= '0;
    in_ch.raw_day     <= '0;
    in_ch.raw_month   <= '0;
    in_ch.raw_year    <= '0;
    in_ch.raw_century <= '0;
    in_ch.status_b    <= '0;
    in_ch.update_busy <= 1'b0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();
    for (int p = 0; p < NUM_PLANS; p++) begin
      drain();
      program_reg(REG_CENTURY, CFG_DW'(plans[p].cp));
      program_reg(REG_TZ, CFG_DW'(plans[p].tz));
      program_reg(REG_BASE, CFG_DW'(plans[p].base));
      random_items(PLAN_ITEMS);
    end
    drain();

    $display("Sent %0d snapshots plus ignored busy ones, %0d stable times checked,",
             snapshots_taken, board.stable_seen);
    $display("over %0d register settings with stalls on both channels.", NUM_PLANS + 1);
    if (board.failures() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", board.failures());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side: random backpressure, check every accepted item
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_result('{out_ch.stable, out_ch.out_second, out_ch.out_minute,
                             out_ch.out_hour, out_ch.out_day, out_ch.out_month,
                             out_ch.out_year});
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!out_calm && $urandom_range(0, 99) < 30) begin
        stall = pick_gap() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_psel || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $realtime, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> files.f
sv/rsn_pkg.sv
sv/rsn_in_if.sv
sv/rsn_out_if.sv
sv/rsn_lane.sv
sv/rsn_merge.sv
sv/rtc_snapshot_normalizer.sv
bench/tb_rtc_snapshot_normalizer.sv
